// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the timer core.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a fixed message
`define CSA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("timer core assertion failed");

// same, with a caller supplied message string
`define CSA_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

`endif

// File: sv/csa_pkg.sv
// Types, constants and arithmetic helpers for the countdown/stopwatch timer.
// Used by csa_step and countdown_stopwatch_alarm_core; depends on nothing.
package csa_pkg;

	localparam int CSA_SNOOZE_MS_DEF = 300000;
	localparam int RING_WINDOW_MS = 30000;
	localparam int SNOOZE_LIMIT = 5;
	localparam int MIN_VALUE_MS = 1000;

	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 64;

	typedef logic signed [47:0] wide_t;
	typedef logic signed [44:0] s45_t;

	localparam wide_t S45_MAX_W = 48'sh0FFF_FFFF_FFFF;
	localparam wide_t S45_MIN_W = 48'shF000_0000_0000;
	localparam logic [47:0] U45_MAX_W = 48'h1FFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		OP_CHECK,
		OP_ADD_CD,
		OP_ADD_SW,
		OP_PAUSE,
		OP_REWIND,
		OP_RESTART,
		OP_RESET,
		OP_LOAD
	} opcode_t;

	typedef enum logic [1:0] {
		ALERT_NONE,
		ALERT_RING,
		ALERT_PULSE
	} alert_t;

	typedef struct packed {
		s45_t        length;
		s45_t        soe;          // start time while running, elapsed while paused
		s45_t        base_length;
		logic        pause;
		logic        vib;
		logic        elapsed;
		logic [2:0]  snooze_used;
		logic        repeat_mode;
		logic [7:0]  repeats_left;
		logic [7:0]  repeats_base;
	} csa_state_t;

	typedef struct packed {
		logic [44:0] value_ms;
		logic        counting_up;
		logic        paused;
		logic        ringing;
		alert_t      alert;
		logic        expired;
		logic [7:0]  repeats_remaining;
	} csa_result_t;

	localparam csa_state_t CSA_STATE_RST = '{
		length: '0, soe: '0, base_length: '0, pause: 1'b1, vib: 1'b0,
		elapsed: 1'b0, snooze_used: '0, repeat_mode: 1'b0,
		repeats_left: '0, repeats_base: '0
	};

	function automatic wide_t sx45(input s45_t x);
		return {{3{x[44]}}, x};
	endfunction

	function automatic s45_t sat45(input wide_t v);
		s45_t r;
		if (v > S45_MAX_W) begin
			r = s45_t'(S45_MAX_W);
		end else if (v < S45_MIN_W) begin
			r = s45_t'(S45_MIN_W);
		end else begin
			r = v[44:0];
		end
		return r;
	endfunction

	function automatic logic [47:0] mag48(input wide_t v);
		return v[47] ? 48'(-v) : 48'(v);
	endfunction

	function automatic logic [44:0] abs_sat45(input wide_t v);
		logic [47:0] m;
		m = mag48(v);
		return (m > U45_MAX_W) ? '1 : m[44:0];
	endfunction

endpackage

// File: sv/csa_step.sv
// Combinational step of the timer: next state and result word for one event.
// Depends on csa_pkg.
module csa_step
	import csa_pkg::*;
#(
	parameter int SNOOZE_MS = CSA_SNOOZE_MS_DEF
) (
	input  csa_state_t        cur,
	input  opcode_t           opcode,
	input  logic [43:0]       now_ms,
	input  logic signed [31:0] amount_ms,
	input  logic              repeat_on,
	input  logic [7:0]        repeat_total,
	output csa_state_t        nxt,
	output csa_result_t       res
);

	wide_t  now_w;
	wide_t  amt_w;
	wide_t  soe_w;
	wide_t  el_c;
	wide_t  raw_c;
	logic   fire;
	logic   rep_hit;
	logic   past_window;
	wide_t  add_amt;
	s45_t   len_add;
	wide_t  raw_add;
	logic   too_small;
	logic   do_add;
	alert_t alert_c;
	wide_t  el_n;
	wide_t  raw_n;

	assign now_w = {4'b0, now_ms};
	assign amt_w = {{16{amount_ms[31]}}, amount_ms};
	assign soe_w = sx45(cur.soe);
	assign el_c  = cur.pause ? soe_w : now_w - soe_w;
	assign raw_c = sx45(cur.length) - el_c;

	assign fire        = (raw_c <= 48'sd0) && !cur.pause && cur.vib;
	assign rep_hit     = cur.repeat_mode && (cur.repeats_left > 8'd1);
	assign past_window = mag48(raw_c) > 48'(RING_WINDOW_MS);

	// shared add-countdown path: checks re-arm with base length or snooze time
	assign add_amt = (opcode == OP_CHECK) ? (rep_hit ? sx45(cur.base_length) : 48'(SNOOZE_MS))
	                                      : amt_w;
	assign len_add   = sat45(sx45(cur.length) + add_amt);
	assign raw_add   = sx45(len_add) - el_c;
	assign too_small = mag48(raw_add) < 48'(MIN_VALUE_MS);

	always_comb begin
		nxt = cur;
		alert_c = ALERT_NONE;
		do_add = 1'b0;
		case (opcode)
			OP_CHECK: begin
				if (fire) begin
					nxt.elapsed = 1'b1;
					if (rep_hit) begin
						nxt.repeats_left = cur.repeats_left - 8'd1;
						do_add = 1'b1;
						alert_c = ALERT_PULSE;
					end else if (past_window) begin
						nxt.vib = 1'b0;
						if (cur.snooze_used < 3'(SNOOZE_LIMIT)) begin
							nxt.snooze_used = cur.snooze_used + 3'd1;
							do_add = 1'b1;
						end
					end else begin
						alert_c = ALERT_RING;
					end
				end
			end
			OP_ADD_CD: begin
				do_add = 1'b1;
			end
			OP_ADD_SW: begin
				nxt.soe = cur.pause ? sat45(soe_w + amt_w) : sat45(soe_w - amt_w);
				nxt.elapsed = 1'b0;
			end
			OP_PAUSE: begin
				nxt.soe = sat45(now_w - soe_w);
				nxt.pause = !cur.pause;
			end
			OP_REWIND: begin
				nxt.soe = '0;
				nxt.pause = 1'b1;
				if (cur.length != 45'sd0) begin
					nxt.vib = 1'b1;
				end
				nxt.elapsed = 1'b0;
			end
			OP_RESTART: begin
				nxt.length = (cur.base_length > 45'sd0) ? cur.base_length : '0;
				nxt.soe = cur.pause ? '0 : {1'b0, now_ms};
				nxt.vib = cur.base_length > 45'sd0;
				if (cur.repeat_mode) begin
					nxt.repeats_left = cur.repeats_base;
				end
				nxt.snooze_used = '0;
				nxt.elapsed = 1'b0;
			end
			OP_RESET: begin
				nxt = CSA_STATE_RST;
			end
			OP_LOAD: begin
				nxt.base_length = {{13{amount_ms[31]}}, amount_ms};
				nxt.repeat_mode = repeat_on;
				nxt.repeats_base = repeat_total;
				nxt.repeats_left = repeat_total;
			end
			default: begin
				nxt = cur;
			end
		endcase

		if (do_add) begin
			nxt.length = len_add;
			if (too_small) begin
				nxt = CSA_STATE_RST;
			end
			if (nxt.length > 45'sd0) begin
				nxt.vib = 1'b1;
			end
			nxt.elapsed = 1'b0;
		end
	end

	assign el_n  = nxt.pause ? sx45(nxt.soe) : now_w - sx45(nxt.soe);
	assign raw_n = sx45(nxt.length) - el_n;

	assign res.value_ms          = abs_sat45(raw_n);
	assign res.counting_up       = raw_n <= 48'sd0;
	assign res.paused            = nxt.pause;
	assign res.ringing           = (raw_n <= 48'sd0) && !nxt.pause && nxt.vib;
	assign res.alert             = alert_c;
	assign res.expired           = nxt.elapsed;
	assign res.repeats_remaining = nxt.repeats_left;

endmodule

// File: sv/countdown_stopwatch_alarm_core.sv
// Top level of the countdown/stopwatch alarm timer: input register, timer state,
// result register. Depends on csa_pkg and csa_step.

// One event enters per clock while s_axis_tready is high. An event is held in the
// input register, is applied to the timer state by a single combinational step, and
// its result word is stored in the result register that drives the master side. Throughput
// is one event per cycle as long as the result side takes words; while a result waits, the
// input register still takes one more event. The snooze step is SNOOZE_MS.
module countdown_stopwatch_alarm_core
	import csa_pkg::*;
#(
	parameter int SNOOZE_MS = CSA_SNOOZE_MS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// now_ms[43:0], amount_ms[75:44], repeat_on[76], repeat_total[84:77], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// opcode[2:0]
	input  logic [2:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// value_ms[44:0], counting_up[45], paused[46], ringing[47], alert[49:48],
	// expired[50], repeats_remaining[58:51], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic               valid_s1;
	opcode_t            opcode_s1;
	logic [43:0]        now_s1;
	logic signed [31:0] amount_s1;
	logic               repeat_on_s1;
	logic [7:0]         repeat_total_s1;

	csa_state_t  state_q;
	csa_state_t  state_nxt;
	csa_result_t res;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  advance;
	logic                  take_in;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1       <= opcode_t'(s_axis_tuser);
			now_s1          <= s_axis_tdata[43:0];
			amount_s1       <= s_axis_tdata[75:44];
			repeat_on_s1    <= s_axis_tdata[76];
			repeat_total_s1 <= s_axis_tdata[84:77];
		end
	end

	csa_step #(
		.SNOOZE_MS(SNOOZE_MS)
	) u_step (
		.cur         (state_q),
		.opcode      (opcode_s1),
		.now_ms      (now_s1),
		.amount_ms   (amount_s1),
		.repeat_on   (repeat_on_s1),
		.repeat_total(repeat_total_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CSA_STATE_RST;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {5'b0, res.repeats_remaining, res.expired, res.alert,
			             res.ringing, res.paused, res.counting_up, res.value_ms};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: sv/csa_checker.sv
// Port-level checker for countdown_stopwatch_alarm_core, bound to the top level.
// Depends on assert_macros.svh and csa_pkg.
`include "assert_macros.svh"

module csa_checker
	import csa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [44:0] value_ms;
	logic        counting_up;
	logic        paused;
	logic        ringing;
	logic [1:0]  alert;
	logic        expired;
	logic        stall;

	assign value_ms    = m_axis_tdata[44:0];
	assign counting_up = m_axis_tdata[45];
	assign paused      = m_axis_tdata[46];
	assign ringing     = m_axis_tdata[47];
	assign alert       = m_axis_tdata[49:48];
	assign expired     = m_axis_tdata[50];
	assign stall       = m_axis_tvalid && !m_axis_tready;

	// a stalled word stays put
	`CSA_ASSERT(a_hold, clk, arst_n, stall |=> m_axis_tvalid && $stable(m_axis_tdata))
	// ringing only while running past zero
	`CSA_ASSERT(a_ring_mode, clk, arst_n, m_axis_tvalid && ringing |-> counting_up && !paused)
	// a ring alert leaves the timer expired and ringing
	`CSA_ASSERT(a_ring_alert, clk, arst_n, m_axis_tvalid && alert == ALERT_RING |-> ringing)
	`CSA_ASSERT(a_ring_exp, clk, arst_n, m_axis_tvalid && alert == ALERT_RING |-> expired)
	// a zero reading counts as past zero
	`CSA_ASSERT_MSG(a_zero_up, clk, arst_n, m_axis_tvalid && value_ms == '0 |-> counting_up, "zero")

endmodule

bind countdown_stopwatch_alarm_core csa_checker u_csa_checker (.*);

// File: test/tb_countdown_stopwatch_alarm_core.sv
// Testbench for countdown_stopwatch_alarm_core: directed and random timer events,
// results checked against an in-bench model of the timer, random stalls on both sides.
// Depends on csa_pkg and the timer core RTL.
module tb_countdown_stopwatch_alarm_core
	import csa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SNOOZE_STEP_MS = 300000;
	localparam longint RING_SPAN_MS = 30000;
	localparam int SNOOZE_MAX = 5;
	localparam longint SHORT_TIMER_MS = 1000;
	localparam longint S45_HI = 64'sh0000_0FFF_FFFF_FFFF;
	localparam longint S45_LO = -S45_HI - 1;
	localparam longint U45_TOP = 64'sh0000_1FFF_FFFF_FFFF;
	localparam longint NOW_MAX = 64'sh0000_0FFF_FFFF_FFFF;
	localparam longint AMT_MAX = 64'sd2147483647;
	localparam longint AMT_MIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 3000;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic [44:0] value_ms;
		logic        counting_up;
		logic        paused;
		logic        ringing;
		alert_t      alert;
		logic        expired;
		logic [7:0]  repeats_remaining;
	} timer_reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [2:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// timer state as the core should hold it
	s45_t       tm_length;
	s45_t       tm_soe;
	s45_t       tm_base;
	bit         tm_paused;
	bit         tm_vib;
	bit         tm_elapsed;
	bit [2:0]   tm_snoozes;
	bit         tm_repeat;
	bit [7:0]   tm_reps_left;
	bit [7:0]   tm_reps_base;

	timer_reading_t expected_readings[$];
	int mismatches = 0;
	int results_seen = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;
	longint wall_ms;

	countdown_stopwatch_alarm_core #(
		.SNOOZE_MS(SNOOZE_STEP_MS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic s45_t clamp45(input longint v);
		if (v > S45_HI) return s45_t'(S45_HI);
		if (v < S45_LO) return s45_t'(S45_LO);
		return s45_t'(v);
	endfunction

	function automatic logic [44:0] magnitude(input longint v);
		longint a;
		a = (v < 0) ? -v : v;
		if (a > U45_TOP) return '1;
		return a[44:0];
	endfunction

	// length minus elapsed; soe holds the start time while running
	function automatic longint signed_remaining(input longint now);
		longint el;
		el = tm_paused ? longint'(tm_soe) : now - longint'(tm_soe);
		return longint'(tm_length) - el;
	endfunction

	function automatic void clear_timer();
		tm_length = '0;
		tm_soe = '0;
		tm_base = '0;
		tm_paused = 1'b1;
		tm_vib = 1'b0;
		tm_elapsed = 1'b0;
		tm_snoozes = '0;
		tm_repeat = 1'b0;
		tm_reps_left = '0;
		tm_reps_base = '0;
	endfunction

	function automatic void extend_countdown(input longint amt, input longint now);
		tm_length = clamp45(longint'(tm_length) + amt);
		// less than a second left wipes the timer
		if (magnitude(signed_remaining(now)) < SHORT_TIMER_MS)
			clear_timer();
		if (tm_length > 0)
			tm_vib = 1'b1;
		tm_elapsed = 1'b0;
	endfunction

	function automatic timer_reading_t apply_event(input opcode_t op, input longint now,
			input longint amt, input bit rep_on, input bit [7:0] rep_total);
		timer_reading_t r;
		longint left;
		alert_t al;
		al = ALERT_NONE;
		case (op)
			OP_CHECK: begin
				if (signed_remaining(now) <= 0 && !tm_paused && tm_vib) begin
					tm_elapsed = 1'b1;
					if (tm_repeat && tm_reps_left > 1) begin
						tm_reps_left--;
						extend_countdown(longint'(tm_base), now);
						al = ALERT_PULSE;
					end else if (magnitude(signed_remaining(now)) > RING_SPAN_MS) begin
						tm_vib = 1'b0;
						if (tm_snoozes < SNOOZE_MAX) begin
							tm_snoozes++;
							extend_countdown(SNOOZE_STEP_MS, now);
						end
					end else begin
						al = ALERT_RING;
					end
				end
			end
			OP_ADD_CD: extend_countdown(amt, now);
			OP_ADD_SW: begin
				tm_soe = tm_paused ? clamp45(longint'(tm_soe) + amt)
				                   : clamp45(longint'(tm_soe) - amt);
				tm_elapsed = 1'b0;
			end
			OP_PAUSE: begin
				tm_soe = clamp45(now - longint'(tm_soe));
				tm_paused = !tm_paused;
			end
			OP_REWIND: begin
				tm_soe = '0;
				tm_paused = 1'b1;
				if (tm_length != 0)
					tm_vib = 1'b1;
				tm_elapsed = 1'b0;
			end
			OP_RESTART: begin
				tm_length = (tm_base > 0) ? tm_base : '0;
				tm_soe = tm_paused ? '0 : s45_t'(now);
				tm_vib = (tm_length > 0);
				if (tm_repeat)
					tm_reps_left = tm_reps_base;
				tm_snoozes = '0;
				tm_elapsed = 1'b0;
			end
			OP_RESET: clear_timer();
			OP_LOAD: begin
				tm_base = s45_t'(amt);
				tm_repeat = rep_on;
				tm_reps_base = rep_total;
				tm_reps_left = rep_total;
			end
			default: ;
		endcase
		left = signed_remaining(now);
		r.value_ms = magnitude(left);
		r.counting_up = (left <= 0);
		r.paused = tm_paused;
		r.ringing = (left <= 0) && !tm_paused && tm_vib;
		r.alert = al;
		r.expired = tm_elapsed;
		r.repeats_remaining = tm_reps_left;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input longint got_v, input longint want_v);
		if (got_v != want_v)
			report_mismatch($sformatf("result %0d %s got %0h expected %0h",
				results_seen, name, got_v, want_v));
	endtask

	// called right after a rising edge; returns at the edge that takes the word
	task automatic send_event(input opcode_t op, input longint now, input longint amount,
			input bit rep_on, input bit [7:0] rep_total);
		longint now_f;
		longint amt_f;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		now_f = now & NOW_MAX;
		amt_f = longint'($signed(amount[31:0]));
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b000, rep_total, rep_on, amount[31:0], now[43:0]};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_readings.push_back(apply_event(op, now_f, amt_f, rep_on, rep_total));
	endtask

	task automatic send_random_event();
		send_event(opcode_t'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom,
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_readings.size() != 0);
	endtask

	// load, restart, run, then a string of checks, with other events mixed in, while time moves on
	task automatic run_alarm_cycle();
		longint base;
		longint step;
		int checks;
		bit long_overrun;
		wall_ms = longint'({$urandom_range(0, 32'h7FF), $urandom});
		case ($urandom_range(0, 9))
			0: base = $urandom_range(0, 999);
			1: base = -longint'($urandom_range(0, 50000));
			default: base = $urandom_range(1000, 60000);
		endcase
		long_overrun = ($urandom_range(0, 3) == 0);
		send_event(OP_LOAD, wall_ms, base, 1'($urandom_range(0, 1)),
			($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
			                            : 8'($urandom_range(0, 5)));
		wall_ms += $urandom_range(0, 2000);
		send_event(OP_RESTART, wall_ms, 0, 1'b0, 8'd0);
		checks = long_overrun ? 9 : $urandom_range(4, 16);
		repeat (checks) begin
			if (tm_paused && $urandom_range(0, 3) != 0) begin
				wall_ms += $urandom_range(0, 3000);
				send_event(OP_PAUSE, wall_ms, 0, 1'b0, 8'd0);
			end
			if (long_overrun) begin
				// jumps past each snooze, to run out the snooze budget
				wall_ms += $urandom_range(300000, 400000);
				send_event(OP_CHECK, wall_ms, 0, 1'b0, 8'd0);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: step = $urandom_range(0, 20000);
					5, 6, 7: step = $urandom_range(20000, 60000);
					8: step = $urandom_range(250000, 400000);
					default: step = -1;
				endcase
				if (step >= 0) begin
					wall_ms += step;
					send_event(OP_CHECK, wall_ms, 0, 1'b0, 8'd0);
				end else begin
					wall_ms += $urandom_range(0, 5000);
					case ($urandom_range(0, 4))
						0: send_event(OP_ADD_CD, wall_ms,
							longint'($urandom_range(0, 65000)) - 5000, 1'b0, 8'd0);
						1: send_event(OP_ADD_SW, wall_ms,
							longint'($urandom_range(0, 65000)) - 5000, 1'b0, 8'd0);
						2: send_event(OP_PAUSE, wall_ms, 0, 1'b0, 8'd0);
						3: send_event(OP_REWIND, wall_ms, 0, 1'b0, 8'd0);
						default: send_event(OP_RESTART, wall_ms, 0, 1'b0, 8'd0);
					endcase
				end
			end
		end
	endtask

	task automatic test_directed_cases();
		send_event(OP_CHECK, 0, 0, 1'b0, 8'd0);
		send_event(OP_ADD_CD, 0, 500, 1'b0, 8'd0);          // under a second: wipe
		send_event(OP_ADD_CD, NOW_MAX, AMT_MAX, 1'b0, 8'd0);
		send_event(OP_ADD_CD, NOW_MAX, AMT_MIN, 1'b0, 8'd0);  // lands on -1 ms: wipe
		send_event(OP_ADD_CD, 0, AMT_MIN, 1'b0, 8'd0);
		send_event(OP_ADD_SW, 0, AMT_MIN, 1'b0, 8'd0);
		// toggles at the time extremes walk the start/elapsed value into saturation
		send_event(OP_PAUSE, 0, 0, 1'b0, 8'd0);
		send_event(OP_PAUSE, NOW_MAX, 0, 1'b0, 8'd0);
		send_event(OP_PAUSE, 0, 0, 1'b0, 8'd0);
		send_event(OP_PAUSE, NOW_MAX, 0, 1'b0, 8'd0);
		send_event(OP_PAUSE, 0, 0, 1'b0, 8'd0);
		send_event(OP_CHECK, NOW_MAX, 0, 1'b0, 8'd0);        // value saturates
		send_event(OP_ADD_SW, NOW_MAX, AMT_MAX, 1'b0, 8'd0);
		send_event(OP_REWIND, 0, 0, 1'b0, 8'd0);
		send_event(OP_RESET, NOW_MAX, AMT_MAX, 1'b1, 8'd255);
		// 5 s repeating timer: two pulses, then ring, then snooze
		send_event(OP_LOAD, 0, 5000, 1'b1, 8'd3);
		send_event(OP_RESTART, 0, 0, 1'b0, 8'd0);
		send_event(OP_PAUSE, 1000, 0, 1'b0, 8'd0);
		send_event(OP_CHECK, 6000, 0, 1'b0, 8'd0);
		send_event(OP_CHECK, 11000, 0, 1'b0, 8'd0);
		send_event(OP_CHECK, 16500, 0, 1'b0, 8'd0);
		send_event(OP_CHECK, 50000, 0, 1'b0, 8'd0);
		// negative base: restart gives a stopwatch
		send_event(OP_LOAD, 55000, -3000, 1'b0, 8'd255);
		send_event(OP_RESTART, 60000, 0, 1'b0, 8'd0);
		send_event(OP_ADD_CD, 60500, 0, 1'b0, 8'd0);
	endtask

	task automatic test_alarm_cycles(input int cycles);
		repeat (cycles)
			run_alarm_cycle();
	endtask

	task automatic test_random_events(input int count);
		repeat (count)
			send_random_event();
	endtask

	// output held off long enough that the core stalls its input
	task automatic test_receiver_holdoff();
		int saved_tx;
		saved_tx = tx_idle_pct;
		tx_idle_pct = 0;
		rx_hold_req = 300;
		repeat (30)
			send_random_event();
		tx_idle_pct = saved_tx;
	endtask

	task automatic test_drain_pause();
		run_alarm_cycle();
		wait_drained();
		run_alarm_cycle();
	endtask

	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_result
		timer_reading_t got;
		timer_reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.value_ms = m_axis_tdata[44:0];
			got.counting_up = m_axis_tdata[45];
			got.paused = m_axis_tdata[46];
			got.ringing = m_axis_tdata[47];
			got.alert = alert_t'(m_axis_tdata[49:48]);
			got.expired = m_axis_tdata[50];
			got.repeats_remaining = m_axis_tdata[58:51];
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("result %0d came with nothing expected",
					results_seen));
			end else begin
				want = expected_readings.pop_front();
				compare_field("value_ms", got.value_ms, want.value_ms);
				compare_field("counting_up", got.counting_up, want.counting_up);
				compare_field("paused", got.paused, want.paused);
				compare_field("ringing", got.ringing, want.ringing);
				compare_field("alert", got.alert, want.alert);
				compare_field("expired", got.expired, want.expired);
				compare_field("repeats_remaining", got.repeats_remaining,
					want.repeats_remaining);
			end
			results_seen++;
		end
	end

	// a word moving on either side resets the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_CHECK;
		clear_timer();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 34;
		rx_idle_pct = 79;
		test_directed_cases();
		test_alarm_cycles(10);
		test_random_events(60);
		test_receiver_holdoff();

		tx_idle_pct = 79;
		rx_idle_pct = 34;
		test_alarm_cycles(10);
		test_random_events(60);
		test_drain_pause();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_alarm_cycles(10);
		test_random_events(60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
